### src/vertex_transform_project_extent_core_defines.svh
// Assertion macros used by the checker file.
`ifndef VERTEX_TRANSFORM_PROJECT_EXTENT_CORE_DEFINES_SVH
`define VERTEX_TRANSFORM_PROJECT_EXTENT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define VTPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define VTPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset
`define VTPE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/vtpe_pkg.sv
// Shared types and constants of the vertex transform and projection block.
package vtpe_pkg;

  localparam int SCREEN_W    = 320;
  localparam int SCREEN_H    = 240;
  localparam int FOCAL_RATIO = -2;

  // projection gain K2 = FOCAL_RATIO * SCREEN_W, sized for the full range
  localparam int K2_W  = 18;
  localparam logic signed [K2_W-1:0] K2 = K2_W'(FOCAL_RATIO * SCREEN_W);

  localparam logic signed [15:0] CENTRE_X = 16'(SCREEN_W / 2);
  localparam logic signed [15:0] CENTRE_Y = 16'(SCREEN_H / 2);
  localparam logic signed [15:0] LIM_X    = 16'(SCREEN_W);
  localparam logic signed [15:0] LIM_Y    = 16'(SCREEN_H);

  // datapath widths
  localparam int COORD_W = 33;                 // view coord, negated y included
  localparam int N_W     = COORD_W + K2_W;     // coord * K2
  localparam int NUM_W   = N_W + 1;            // coord * K2 + z
  localparam int DEN_W   = 33;                 // |2 z|
  localparam int CNT_W   = $clog2(NUM_W);

  // configuration registers
  localparam int CFG_N     = 6;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               page;
    logic               eop;
  } item_t;

  typedef struct packed {
    logic avail;
    logic full;
  } qstat_t;

endpackage

### src/vertex_transform_project_extent_core.sv
// Top level: request queue in front, transform and projection engine behind.
// A vertex passes the matrix multiply, then per axis the numerator multiply and the divide,
// then the extent update; a zero-depth vertex skips both divides.
// The engine works on one vertex at a time, paced by the 1-bit-per-cycle divider run twice
// per vertex and the 12-step matrix multiply on one multiplier; output stalls add time.
// Synchronous active-low reset loads identity matrix rows and empty rectangles.
module vertex_transform_project_extent_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vtpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             in_vertex_x,
  input  logic signed [31:0]             in_vertex_y,
  input  logic signed [31:0]             in_vertex_z,
  input  logic signed [31:0]             in_vertex_w,
  input  logic                           in_page,
  input  logic                           in_end_of_polygon,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             out_screen_x,
  output logic signed [15:0]             out_screen_y,
  output logic                           out_zero_depth,
  output logic                           out_polygon_done,
  output logic [14:0]                    out_extent_left_out,
  output logic [14:0]                    out_extent_right_out,
  output logic [14:0]                    out_extent_top_out,
  output logic [14:0]                    out_extent_bottom_out
);

  vtpe_pkg::item_t  in_item;
  vtpe_pkg::item_t  q_data;
  vtpe_pkg::qstat_t q_stat;
  logic             q_pop;

  // pack the incoming request
  always_comb begin
    in_item.x    = in_vertex_x;
    in_item.y    = in_vertex_y;
    in_item.z    = in_vertex_z;
    in_item.w    = in_vertex_w;
    in_item.page = in_page;
    in_item.eop  = in_end_of_polygon;
  end

  assign in_stall = q_stat.full;

  vtpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !in_stall),
    .push_data (in_item),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  vtpe_engine u_engine (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .q_stat                (q_stat),
    .q_data                (q_data),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_screen_x          (out_screen_x),
    .out_screen_y          (out_screen_y),
    .out_zero_depth        (out_zero_depth),
    .out_polygon_done      (out_polygon_done),
    .out_extent_left_out   (out_extent_left_out),
    .out_extent_right_out  (out_extent_right_out),
    .out_extent_top_out    (out_extent_top_out),
    .out_extent_bottom_out (out_extent_bottom_out)
  );

endmodule

### src/vtpe_queue.sv
// Two-entry request queue between the accepting front and the compute back.
module vtpe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vtpe_pkg::item_t push_data,
  input  logic            pop,
  output vtpe_pkg::item_t pop_data,
  output vtpe_pkg::qstat_t stat
);

  vtpe_pkg::item_t mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.avail = (cnt_r != 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

endmodule

### src/vtpe_engine.sv
// Back end: matrix transform, iterative projection divide, extent tracking.
module vtpe_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vtpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                      cfg_wdata,
  input  vtpe_pkg::qstat_t                 q_stat,
  input  vtpe_pkg::item_t                  q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_screen_x,
  output logic signed [15:0]               out_screen_y,
  output logic                             out_zero_depth,
  output logic                             out_polygon_done,
  output logic [14:0]                      out_extent_left_out,
  output logic [14:0]                      out_extent_right_out,
  output logic [14:0]                      out_extent_top_out,
  output logic [14:0]                      out_extent_bottom_out
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_NUM  = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EXT  = 3'd6;

  localparam int NW = vtpe_pkg::NUM_W;
  localparam int DW = vtpe_pkg::DEN_W;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF)       sat32 = 32'sh7FFF_FFFF;
    else if (v < -50'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else                            sat32 = v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [NW:0] v);
    if (v > (NW+1)'(32767))         sat16 = 16'sh7FFF;
    else if (v < -(NW+1)'(32768))   sat16 = 16'sh8000;
    else                            sat16 = v[15:0];
  endfunction

  logic [2:0]          state_r;
  vtpe_pkg::item_t     item_r;
  logic [63:0]         cfg_r [vtpe_pkg::CFG_N];
  logic [3:0]          step_r;
  logic signed [63:0]  prod_r;
  logic signed [49:0]  acc_r;
  logic signed [31:0]  vx_r, vy_r, vz_r;
  logic                axis_r;
  logic signed [vtpe_pkg::N_W-1:0] n_r;
  logic                neg_r;
  logic [NW-1:0]       quo_r;
  logic [DW:0]         rem_r;
  logic [DW-1:0]       dmag_r;
  logic [vtpe_pkg::CNT_W-1:0] cnt_r;
  logic signed [15:0]  px_r, py_r;
  logic signed [15:0]  rl_r [2];
  logic signed [15:0]  rr_r [2];
  logic signed [15:0]  rt_r [2];
  logic signed [15:0]  rb_r [2];
  logic                out_valid_r;
  logic signed [15:0]  osx_r, osy_r;
  logic                ozd_r, opd_r;
  logic [14:0]         ol_r, orr_r, ot_r, ob_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= 64'h0000_0000_0001_0000;
      cfg_r[1] <= 64'h0;
      cfg_r[2] <= 64'h0001_0000_0000_0000;
      cfg_r[3] <= 64'h0;
      cfg_r[4] <= 64'h0;
      cfg_r[5] <= 64'h0000_0000_0001_0000;
    end else if (cfg_we && (cfg_index < vtpe_pkg::CFG_IDX_W'(vtpe_pkg::CFG_N))) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // matrix entry and vertex element for the current multiply step
  logic [63:0]        ent_word;
  logic signed [31:0] ent;
  logic signed [31:0] vsel;
  logic [3:0]         prev;
  logic signed [49:0] psum;
  always_comb begin
    ent_word = cfg_r[{step_r[3:2], step_r[1]}];
    ent      = step_r[0] ? ent_word[63:32] : ent_word[31:0];
    case (step_r[1:0])
      2'd0:    vsel = item_r.x;
      2'd1:    vsel = item_r.y;
      2'd2:    vsel = item_r.z;
      default: vsel = item_r.w;
    endcase
    prev = step_r - 4'd1;
    psum = acc_r + {{2{prod_r[63]}}, prod_r[63:16]};
  end

  // projection numerator, divider setup and step
  logic signed [vtpe_pkg::COORD_W-1:0] coord;
  logic signed [NW-1:0] num;
  logic signed [DW-1:0] den;
  logic [DW:0]          trial;
  logic signed [NW:0]   qs;
  logic signed [15:0]   centre;
  logic signed [15:0]   res;
  always_comb begin
    coord  = axis_r ? -{vy_r[31], vy_r} : {vx_r[31], vx_r};
    num    = NW'(n_r) + NW'(vz_r);
    den    = {vz_r, 1'b0};
    trial  = {rem_r[DW-1:0], quo_r[NW-1]};
    centre = axis_r ? vtpe_pkg::CENTRE_Y : vtpe_pkg::CENTRE_X;
    qs     = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    res    = sat16(qs + (NW+1)'(centre));
  end

  // extent update for the selected page
  logic               pg;
  logic signed [15:0] nl, nr, nt, nb;
  logic               out_free;
  always_comb begin
    pg = item_r.page;
    nl = rl_r[pg];
    nr = rr_r[pg];
    nt = rt_r[pg];
    nb = rb_r[pg];
    if (vz_r != 32'sd0) begin
      if (px_r > rr_r[pg]) nr = (px_r < vtpe_pkg::LIM_X) ? px_r : vtpe_pkg::LIM_X;
      if (py_r > rb_r[pg]) nb = (py_r < vtpe_pkg::LIM_Y) ? py_r : vtpe_pkg::LIM_Y;
      if (px_r < rl_r[pg]) nl = (px_r > 16'sd0) ? px_r : 16'sd0;
      if (py_r < rt_r[pg]) nt = (py_r > 16'sd0) ? py_r : 16'sd0;
    end
    out_free = !out_valid_r || !out_stall;
  end

  assign q_pop = (state_r == S_IDLE) && q_stat.avail;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 2; i++) begin
        rl_r[i] <= 16'sh7FFF;
        rr_r[i] <= 16'sd0;
        rt_r[i] <= 16'sh7FFF;
        rb_r[i] <= 16'sd0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_stat.avail) begin
            item_r  <= q_data;
            step_r  <= 4'd0;
            acc_r   <= 50'sd0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // one product per cycle, summed in the next cycle
          if (step_r < 4'd12) prod_r <= ent * vsel;
          if (step_r != 4'd0) begin
            if (prev[1:0] == 2'd3) begin
              acc_r <= 50'sd0;
              case (prev[3:2])
                2'd0:    vx_r <= sat32(psum);
                2'd1:    vy_r <= sat32(psum);
                default: vz_r <= sat32(psum);
              endcase
            end else begin
              acc_r <= psum;
            end
          end
          step_r <= step_r + 4'd1;
          if (step_r == 4'd12) begin
            axis_r  <= 1'b0;
            state_r <= S_NUM;
          end
        end
        S_NUM: begin
          n_r     <= coord * vtpe_pkg::K2;
          state_r <= S_INIT;
        end
        S_INIT: begin
          if (vz_r == 32'sd0) begin
            // zero depth: saturate by numerator sign, centre if it is zero
            res_zero: begin
              logic signed [15:0] z;
              z = (n_r > 0) ? 16'sh7FFF : ((n_r < 0) ? 16'sh8000 : centre);
              if (axis_r) py_r <= z;
              else        px_r <= z;
            end
            axis_r  <= 1'b1;
            state_r <= axis_r ? S_EXT : S_NUM;
          end else begin
            neg_r   <= num[NW-1] ^ den[DW-1];
            quo_r   <= num[NW-1] ? NW'(-num) : NW'(num);
            dmag_r  <= den[DW-1] ? DW'(-den) : DW'(den);
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (trial >= {1'b0, dmag_r}) begin
            rem_r <= trial - {1'b0, dmag_r};
            quo_r <= {quo_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= trial;
            quo_r <= {quo_r[NW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == vtpe_pkg::CNT_W'(NW - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (axis_r) py_r <= res;
          else        px_r <= res;
          axis_r  <= 1'b1;
          state_r <= axis_r ? S_EXT : S_NUM;
        end
        S_EXT: begin
          if (out_free) begin
            rl_r[pg] <= nl;
            rr_r[pg] <= nr;
            rt_r[pg] <= nt;
            rb_r[pg] <= nb;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  logic load;
  assign load = (state_r == S_EXT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      osx_r <= px_r;
      osy_r <= py_r;
      ozd_r <= (vz_r == 32'sd0);
      opd_r <= item_r.eop;
      ol_r  <= nl[14:0];
      orr_r <= nr[14:0];
      ot_r  <= nt[14:0];
      ob_r  <= nb[14:0];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_screen_x          = osx_r;
  assign out_screen_y          = osy_r;
  assign out_zero_depth        = ozd_r;
  assign out_polygon_done      = opd_r;
  assign out_extent_left_out   = ol_r;
  assign out_extent_right_out  = orr_r;
  assign out_extent_top_out    = ot_r;
  assign out_extent_bottom_out = ob_r;

endmodule

### src/vtpe_checker.sv
// Port-level checker for the vertex transform core, bound to the top level.
`include "vertex_transform_project_extent_core_defines.svh"

module vtpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_screen_x,
  input logic               out_zero_depth,
  input logic [14:0]        out_extent_right_out,
  input logic [14:0]        out_extent_bottom_out
);

  // a stalled result keeps its screen x
  `VTPE_ASSERT_NXT(a_hold_x, out_valid && out_stall, out_valid && $stable(out_screen_x), "stalled result changed")

  // right and bottom edges never pass the screen limits
  `VTPE_ASSERT_NOW(a_ext_lim, out_valid, (out_extent_right_out <= 15'(vtpe_pkg::SCREEN_W)) && (out_extent_bottom_out <= 15'(vtpe_pkg::SCREEN_H)), "extent beyond screen")

  // zero depth gives a saturated or centred x
  `VTPE_ASSERT_NOW(a_zd_x, out_valid && out_zero_depth, (out_screen_x == 16'sh7FFF) || (out_screen_x == 16'sh8000) || (out_screen_x == vtpe_pkg::CENTRE_X), "bad zero-depth x")

  // no result right after reset
  `VTPE_ASSERT_RST(a_rst, !rst_n, !out_valid, "result valid after reset")

endmodule

bind vertex_transform_project_extent_core vtpe_checker u_vtpe_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_screen_x          (out_screen_x),
  .out_zero_depth        (out_zero_depth),
  .out_extent_right_out  (out_extent_right_out),
  .out_extent_bottom_out (out_extent_bottom_out)
);
